// ----- hw/rtl/gdta_pkg.sv -----
// Shared types, constants and helper functions for the Gregorian date/time adder.
// Used by gdta_ctrl, gdta_datapath and gregorian_datetime_adder_unit.
// No dependencies.
package gdta_pkg;

    // Addend clamp and saturation limits
    localparam int MAX_ADDEND = 1023;
    localparam int YEAR_MAX   = 4095;
    localparam int HOUR_SAT   = 2047;

    // Calendar constants
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int MON_PER_YEAR  = 12;
    localparam int LEAP_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int FEB_DAYS      = 28;
    localparam int FEB_LEAP_DAYS = 29;

    // Reciprocals for division by a constant: q = (x * RCP) >> shift
    localparam int RCP_60  = 1093;   // 2^16 / 60, rounded up
    localparam int RCP_12  = 5462;   // 2^16 / 12, rounded up
    localparam int RCP_24  = 2731;   // 2^16 / 24, rounded up
    localparam int RCP_400 = 41944;  // 2^24 / 400, rounded up

    // Internal widths
    localparam int YR_W   = 14;  // year while normalizing, before saturation
    localparam int DAYS_W = 11;  // day sum before reduction
    localparam int HRS_W  = 12;  // raw hour sum

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 40;

    // Input item, first field in the highest bits
    typedef struct packed {
        logic [9:0]  add_minutes;
        logic [9:0]  add_hours;
        logic [9:0]  add_days;
        logic [9:0]  add_months;
        logic [11:0] add_years;
        logic [5:0]  base_minute;
        logic [9:0]  base_hour;
        logic [4:0]  base_day;
        logic [3:0]  base_month;
        logic [11:0] base_year;
    } t_in_item;

    // Result item without the overflow flag, first field in the highest bits
    typedef struct packed {
        logic [5:0]  sum_minute;
        logic [10:0] sum_hour;
        logic [4:0]  sum_day;
        logic [3:0]  sum_month;
        logic [11:0] sum_year;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_REM,
        S_DIV2,
        S_REM2,
        S_LOOP
    } t_state;

    typedef struct packed {
        logic load;
        logic sum;
        logic div;
        logic rem;
        logic div2;
        logic rem2;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic fits;
    } t_dp_status;

    function automatic logic [9:0] clamp_add(input logic [9:0] x);
        if (32'(x) > MAX_ADDEND) begin
            return 10'(MAX_ADDEND);
        end
        return x;
    endfunction

    // Month length; month is 1..12 here
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                    len = leap ? 5'(FEB_LEAP_DAYS) : 5'(FEB_DAYS);
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/gdta_datapath.sv -----
// Datapath of the date/time adder: field sums, constant divisions and
// the month-by-month day reduction. Depends on gdta_pkg.
module gdta_datapath (
    input  logic                  i_clk,
    input  gdta_pkg::t_dp_cmd     i_cmd,
    input  gdta_pkg::t_in_item    i_item,
    output gdta_pkg::t_dp_status  o_status,
    output gdta_pkg::t_out_item   o_out,
    output logic                  o_ovf
);

    gdta_pkg::t_in_item  r_in;
    logic                r_duration;
    logic [10:0]         r_min_sum;
    logic [10:0]         r_mon_m1;
    logic [4:0]          r_min_q;
    logic [6:0]          r_mon_q;
    logic [5:0]          r_min_rem;
    logic [gdta_pkg::HRS_W-1:0]  r_hours;
    logic [3:0]          r_month;
    logic [gdta_pkg::YR_W-1:0]   r_year;
    logic [6:0]          r_hour_q;
    logic [5:0]          r_y400_q;
    logic [4:0]          r_hour_rem;
    logic [gdta_pkg::DAYS_W-1:0] r_days;
    logic [8:0]          r_y400;
    gdta_pkg::t_out_item r_out;
    logic                r_ovf;

    logic [21:0] min_prod;
    logic [23:0] mon_prod;
    logic [23:0] hour_prod;
    logic [29:0] y400_prod;
    logic        leap;
    logic [4:0]  dim;
    logic        year_sat;
    logic        hour_sat;

    assign min_prod  = 22'(r_min_sum) * 22'(gdta_pkg::RCP_60);
    assign mon_prod  = 24'(r_mon_m1) * 24'(gdta_pkg::RCP_12);
    assign hour_prod = 24'(r_hours) * 24'(gdta_pkg::RCP_24);
    assign y400_prod = 30'(r_year) * 30'(gdta_pkg::RCP_400);

    // Leap test on the year modulo 400
    assign leap = (r_y400[1:0] == 2'd0)
                  && (r_y400 != 9'(gdta_pkg::CENTURY))
                  && (r_y400 != 9'(2 * gdta_pkg::CENTURY))
                  && (r_y400 != 9'(3 * gdta_pkg::CENTURY));
    assign dim  = gdta_pkg::month_len(r_month, leap);

    assign o_status.fits = r_duration || (r_days <= gdta_pkg::DAYS_W'(dim));

    assign year_sat = 32'(r_year) > gdta_pkg::YEAR_MAX;
    assign hour_sat = 32'(r_hours) > gdta_pkg::HOUR_SAT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in       <= i_item;
            r_duration <= (i_item.base_month == 4'd0);
        end
        if (i_cmd.sum) begin
            r_min_sum <= 11'(r_in.base_minute) + 11'(gdta_pkg::clamp_add(r_in.add_minutes));
            r_mon_m1  <= 11'(r_in.base_month) + 11'(gdta_pkg::clamp_add(r_in.add_months))
                         - 11'd1;
        end
        if (i_cmd.div) begin
            r_min_q <= min_prod[20:16];
            r_mon_q <= mon_prod[22:16];
        end
        if (i_cmd.rem) begin
            r_min_rem <= 6'(r_min_sum - 11'(r_min_q) * 11'(gdta_pkg::MIN_PER_HOUR));
            r_hours   <= gdta_pkg::HRS_W'(r_min_q) + gdta_pkg::HRS_W'(r_in.base_hour)
                         + gdta_pkg::HRS_W'(gdta_pkg::clamp_add(r_in.add_hours));
            r_month   <= 4'(r_mon_m1 - 11'(r_mon_q) * 11'(gdta_pkg::MON_PER_YEAR) + 11'd1);
            r_year    <= gdta_pkg::YR_W'(r_in.base_year) + gdta_pkg::YR_W'(r_in.add_years)
                         + gdta_pkg::YR_W'(r_mon_q);
        end
        if (i_cmd.div2) begin
            r_hour_q <= hour_prod[22:16];
            r_y400_q <= y400_prod[29:24];
        end
        if (i_cmd.rem2) begin
            r_hour_rem <= 5'(r_hours - gdta_pkg::HRS_W'(r_hour_q)
                             * gdta_pkg::HRS_W'(gdta_pkg::HOUR_PER_DAY));
            r_days     <= gdta_pkg::DAYS_W'(r_in.base_day)
                          + gdta_pkg::DAYS_W'(gdta_pkg::clamp_add(r_in.add_days))
                          + gdta_pkg::DAYS_W'(r_hour_q);
            r_y400     <= 9'(r_year - gdta_pkg::YR_W'(r_y400_q)
                             * gdta_pkg::YR_W'(gdta_pkg::LEAP_CYCLE));
        end
        // Drop one month's days and advance the month, carrying into the year
        if (i_cmd.step) begin
            r_days <= r_days - gdta_pkg::DAYS_W'(dim);
            if (r_month == 4'(gdta_pkg::MON_PER_YEAR)) begin
                r_month <= 4'd1;
                r_year  <= r_year + gdta_pkg::YR_W'(1);
                r_y400  <= (r_y400 == 9'(gdta_pkg::LEAP_CYCLE - 1)) ? 9'd0 : r_y400 + 9'd1;
            end else begin
                r_month <= r_month + 4'd1;
            end
        end
        if (i_cmd.capture) begin
            r_out.sum_minute <= r_min_rem;
            if (r_duration) begin
                r_out.sum_year  <= r_in.base_year;
                r_out.sum_month <= 4'd0;
                r_out.sum_day   <= r_in.base_day;
                r_out.sum_hour  <= hour_sat ? 11'(gdta_pkg::HOUR_SAT) : 11'(r_hours);
                r_ovf           <= hour_sat;
            end else begin
                r_out.sum_year  <= year_sat ? 12'(gdta_pkg::YEAR_MAX) : 12'(r_year);
                r_out.sum_month <= r_month;
                r_out.sum_day   <= 5'(r_days);
                r_out.sum_hour  <= 11'(r_hour_rem);
                r_ovf           <= year_sat;
            end
        end
    end

    assign o_out = r_out;
    assign o_ovf = r_ovf;

endmodule

// ----- hw/rtl/gdta_ctrl.sv -----
// Controller of the date/time adder: sequences the datapath steps and
// runs both stream handshakes. Depends on gdta_pkg.
module gdta_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  gdta_pkg::t_dp_status  i_status,
    output gdta_pkg::t_dp_cmd     o_cmd
);

    gdta_pkg::t_state r_state;
    gdta_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdta_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gdta_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gdta_pkg::S_SUM;
                end
            end
            gdta_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = gdta_pkg::S_DIV;
            end
            gdta_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = gdta_pkg::S_REM;
            end
            gdta_pkg::S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = gdta_pkg::S_DIV2;
            end
            gdta_pkg::S_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = gdta_pkg::S_REM2;
            end
            gdta_pkg::S_REM2: begin
                o_cmd.rem2 = 1'b1;
                n_state    = gdta_pkg::S_LOOP;
            end
            gdta_pkg::S_LOOP: begin
                // Hold the finished result until the output register frees up
                if (!i_status.fits) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = gdta_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdta_pkg::S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/gregorian_datetime_adder_unit.sv -----
// Top level of the Gregorian date/time adder: controller plus datapath.
// Depends on gdta_pkg, gdta_ctrl and gdta_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | base date/time and duration, 89 bits in tdata
//  m_axis   | out       | sum date/time in tdata, overflow in tuser
//
// An item passes from its input transfer through the sum, division and
// remainder states into the day reduction loop, which steps off one month
// per cycle (at most 37 months for the largest day sum); a new item is taken
// in the cycle after the result is loaded into the output register.
// Reset is synchronous, active low, and clears the controller only.
// A stalled output holds its result; the next item may run up to its end meanwhile.
module gregorian_datetime_adder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // base_year, base_month, base_day, base_hour, base_minute,
    // add_years, add_months, add_days, add_hours, add_minutes, zero pad
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sum_year, sum_month, sum_day, sum_hour, sum_minute, zero pad
    output logic [39:0] m_axis_tdata,
    // overflow
    output logic [0:0]  m_axis_tuser
);

    gdta_pkg::t_dp_cmd    cmd;
    gdta_pkg::t_dp_status status;
    gdta_pkg::t_in_item   in_item;
    gdta_pkg::t_out_item  out_item;
    logic                 ovf;

    assign in_item = gdta_pkg::t_in_item'(s_axis_tdata[$bits(gdta_pkg::t_in_item)-1:0]);

    gdta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gdta_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_item   (in_item),
        .o_status (status),
        .o_out    (out_item),
        .o_ovf    (ovf)
    );

    assign m_axis_tdata = {
        (gdta_pkg::OUT_TDATA_W - $bits(gdta_pkg::t_out_item))'(0),
        out_item
    };
    assign m_axis_tuser = ovf;

endmodule
